>>> rtl/ptg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pixel to grayscale converter.
// No dependencies; imported by ptg_div, ptg_yuv and the top level.
package ptg_pkg;

  // Input layouts selected by the color_mode register
  typedef enum logic [2:0] {
    MODE_ARGB   = 3'd0,
    MODE_BGRA   = 3'd1,
    MODE_BGR24  = 3'd2,
    MODE_PLANAR = 3'd3,
    MODE_YUYV   = 3'd4
  } mode_t;

  // Register index on the configuration port (paddr bit 2)
  localparam logic REG_COLOR_MODE = 1'b0;
  localparam logic REG_PREMUL     = 1'b1;

  // Where the color channels of result 0 come from
  typedef enum logic [2:0] {
    SRC_RAW,
    SRC_DIV,
    SRC_ZERO,
    SRC_YUV,
    SRC_PAIR
  } src_t;

  // Per-item control carried alongside the divider and YUV pipelines
  typedef struct packed {
    src_t       src;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } ctrl_t;

  // Un-premultiply divider: 16-bit dividend, four quotient bits per stage
  localparam int PTG_DIV_STAGES = 4;
  localparam int PTG_DIV_STEPS  = 4;

  // Luma weights over 1024 with rounding
  localparam logic [17:0] PTG_W_R   = 18'd306;
  localparam logic [17:0] PTG_W_G   = 18'd601;
  localparam logic [17:0] PTG_W_B   = 18'd117;
  localparam logic [17:0] PTG_W_RND = 18'd512;

  // YUV arithmetic word
  typedef logic signed [26:0] ywide_t;

  // Integer BT.601 coefficients (8 fractional bits)
  localparam ywide_t PTG_I_Y   = 27'sd298;
  localparam ywide_t PTG_I_RV  = 27'sd409;
  localparam ywide_t PTG_I_GU  = 27'sd100;
  localparam ywide_t PTG_I_GV  = 27'sd208;
  localparam ywide_t PTG_I_BU  = 27'sd516;
  localparam ywide_t PTG_I_RND = 27'sd128;

  // Packed YUYV coefficients (16 fractional bits)
  localparam ywide_t PTG_F_RV = 27'sd92242;
  localparam ywide_t PTG_F_GU = 27'sd22643;
  localparam ywide_t PTG_F_GV = 27'sd46983;
  localparam ywide_t PTG_F_BU = 27'sd116589;

endpackage

>>> rtl/pixel_to_grayscale_converter.sv
`timescale 1ns / 1ps
// Pixel to grayscale converter top level: APB registers, input capture, luma and output.
// Depends on ptg_pkg, ptg_div (un-premultiply) and ptg_yuv (YUV to RGB lanes).
// Result path: input capture, divider or YUV pipeline, luma stage, output register;
//   the second result of a packed YUYV word strobes on the cycle after the first.
// Throughput: one pixel word per cycle while busy is low; a packed YUYV word holds
//   busy for one cycle; the single result port emits both on consecutive cycles.
// Reset (rst_n, synchronous): color_mode 0, premultiplied 0, all in-flight items dropped.
// The receiver cannot stall: results are strobed on out_valid for one cycle each.
module pixel_to_grayscale_converter (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  // Result channel
  output logic        out_valid,
  output logic [7:0]  out_gray_level,
  output logic        out_last_pixel,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptg_pkg::*;

  localparam int NCH = 3;

  // Configuration registers
  logic [2:0] color_mode_r;
  logic       premul_r;
  logic       cfg_wr;

  // Input capture
  logic       accept;
  logic       mode_ok;
  logic       is_argb;
  logic       busy_r, busy_nxt;
  logic [7:0] a_nxt;
  logic [7:0] ch_nxt [NCH];
  src_t       src_nxt;

  // Stage 1 payload
  logic [15:0] div_num_r [NCH];
  logic [7:0]  div_den_r;
  logic [7:0]  div_quo   [NCH];
  logic [7:0]  ya_r, va_r, yb_r, u_r, vb_r;
  logic        fix_a_r;
  logic [7:0]  ra, ga, ba, rb, gb, bb;

  // Control delay line matching the divider and YUV depth
  logic [PTG_DIV_STAGES:0] vld_r;
  ctrl_t                   ctrl_r [PTG_DIV_STAGES+1];
  ctrl_t                   ctrl_nxt;
  ctrl_t                   ctl;

  // Luma stage
  logic [7:0] l0_r, l0_g, l0_b;
  logic       s6_vld_r, s6_pair_r;
  logic [7:0] gray0_r, gray1_r;

  // Output stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_gray_r, out_gray_nxt;
  logic       out_last_r, out_last_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] pend_gray_r, pend_gray_nxt;

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [17:0] sum;
    sum = 18'(r) * PTG_W_R + 18'(g) * PTG_W_G + 18'(b) * PTG_W_B + PTG_W_RND;
    return sum[17:10];
  endfunction

  // Register writes on the access phase
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 3'(MODE_ARGB);
      premul_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_COLOR_MODE: color_mode_r <= pwdata[2:0];
        REG_PREMUL:     premul_r     <= pwdata[0];
        default:        premul_r     <= premul_r;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      REG_COLOR_MODE: prdata = {29'd0, color_mode_r};
      REG_PREMUL:     prdata = {31'd0, premul_r};
      default:        prdata = '0;
    endcase
  end

  // Decode the pixel word layout and classify the transaction
  always_comb begin
    accept   = start && !busy_r;
    mode_ok  = (color_mode_r <= 3'(MODE_YUYV));
    busy_nxt = accept && (color_mode_r == 3'(MODE_YUYV));
    is_argb  = (color_mode_r == 3'(MODE_ARGB));
    a_nxt     = is_argb ? in_byte0 : in_byte3;
    ch_nxt[0] = is_argb ? in_byte1 : in_byte2;
    ch_nxt[1] = is_argb ? in_byte2 : in_byte1;
    ch_nxt[2] = is_argb ? in_byte3 : in_byte0;
    case (color_mode_r)
      MODE_ARGB, MODE_BGRA: begin
        if (!premul_r) begin
          src_nxt = SRC_RAW;
        end else if (a_nxt == 8'd0) begin
          src_nxt = SRC_ZERO;
        end else begin
          src_nxt = SRC_DIV;
        end
      end
      MODE_BGR24:  src_nxt = SRC_RAW;
      MODE_PLANAR: src_nxt = SRC_YUV;
      MODE_YUYV:   src_nxt = SRC_PAIR;
      default:     src_nxt = SRC_RAW;
    endcase
    ctrl_nxt.src = src_nxt;
    ctrl_nxt.r   = ch_nxt[0];
    ctrl_nxt.g   = ch_nxt[1];
    ctrl_nxt.b   = ch_nxt[2];
  end

  // Hold off the next transaction for one cycle after a packed YUYV word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

  // Capture payload for the divider and YUV lanes; unknown layouts get no valid bit
  always_ff @(posedge clk) begin
    for (int i = 0; i < NCH; i++) begin
      div_num_r[i] <= {ch_nxt[i], 8'h00} - {8'h00, ch_nxt[i]};
    end
    div_den_r <= a_nxt;
    ya_r      <= in_byte0;
    u_r       <= in_byte1;
    va_r      <= (color_mode_r == 3'(MODE_YUYV)) ? in_byte3 : in_byte2;
    fix_a_r   <= (color_mode_r == 3'(MODE_YUYV));
    yb_r      <= in_byte2;
    vb_r      <= in_byte3;
  end

  // Advance the control delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PTG_DIV_STAGES-1:0], accept && mode_ok};
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r[0] <= ctrl_nxt;
    for (int i = 1; i <= PTG_DIV_STAGES; i++) begin
      ctrl_r[i] <= ctrl_r[i-1];
    end
  end

  // Un-premultiply each color channel by alpha
  for (genvar ch = 0; ch < NCH; ch++) begin : g_div
    ptg_div u_div (
      .clk (clk),
      .num (div_num_r[ch]),
      .den (div_den_r),
      .quo (div_quo[ch])
    );
  end

  // YUV lane A: planar pixel or first YUYV pixel; lane B: second YUYV pixel
  ptg_yuv u_yuv_a (
    .clk (clk),
    .y   (ya_r),
    .u   (u_r),
    .v   (va_r),
    .fix (fix_a_r),
    .r   (ra),
    .g   (ga),
    .b   (ba)
  );

  ptg_yuv u_yuv_b (
    .clk (clk),
    .y   (yb_r),
    .u   (u_r),
    .v   (vb_r),
    .fix (1'b1),
    .r   (rb),
    .g   (gb),
    .b   (bb)
  );

  // Pick the color source for the first result
  assign ctl = ctrl_r[PTG_DIV_STAGES];

  always_comb begin
    case (ctl.src)
      SRC_RAW: begin
        l0_r = ctl.r;
        l0_g = ctl.g;
        l0_b = ctl.b;
      end
      SRC_DIV: begin
        l0_r = div_quo[0];
        l0_g = div_quo[1];
        l0_b = div_quo[2];
      end
      SRC_ZERO: begin
        l0_r = 8'd0;
        l0_g = 8'd0;
        l0_b = 8'd0;
      end
      SRC_YUV, SRC_PAIR: begin
        l0_r = ra;
        l0_g = ga;
        l0_b = ba;
      end
      default: begin
        l0_r = ctl.r;
        l0_g = ctl.g;
        l0_b = ctl.b;
      end
    endcase
  end

  // Weight and round both lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= vld_r[PTG_DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    s6_pair_r <= (ctl.src == SRC_PAIR);
    gray0_r   <= luma(l0_r, l0_g, l0_b);
    gray1_r   <= luma(rb, gb, bb);
  end

  // Emit the first result, park the second of a pair for the next cycle
  always_comb begin
    out_valid_nxt = 1'b0;
    out_gray_nxt  = out_gray_r;
    out_last_nxt  = out_last_r;
    pend_nxt      = 1'b0;
    pend_gray_nxt = pend_gray_r;
    if (s6_vld_r) begin
      out_valid_nxt = 1'b1;
      out_gray_nxt  = gray0_r;
      out_last_nxt  = !s6_pair_r;
      pend_nxt      = s6_pair_r;
      pend_gray_nxt = gray1_r;
    end else if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_gray_nxt  = pend_gray_r;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_gray_r  <= out_gray_nxt;
    out_last_r  <= out_last_nxt;
    pend_gray_r <= pend_gray_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_gray_level = out_gray_r;
  assign out_last_pixel = out_last_r;

  // A new result never lands while the second result of a pair is parked
  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(s6_vld_r && pend_r))
    else $error("result arrived while a parked result was pending");

  // The first result of a pair is always followed by its last result
  a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_pixel) |=> (out_valid && out_last_pixel))
    else $error("pair first result not followed by its last result");

  // The bubble after a packed word lasts exactly one cycle
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // A parked result means the strobe currently shows a non-final result
  a_pend_shape: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_valid_r && !out_last_r))
    else $error("parked result without a preceding first result");

endmodule

>>> rtl/ptg_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: 16-bit dividend by 8-bit divisor, low 8 quotient bits.
// Depends on ptg_pkg for the stage and step counts.
module ptg_div (
  input  logic        clk,
  input  logic [15:0] num,
  input  logic [7:0]  den,
  output logic [7:0]  quo
);
  import ptg_pkg::*;

  logic [7:0]  rem_r   [PTG_DIV_STAGES];
  logic [15:0] num_r   [PTG_DIV_STAGES];
  logic [7:0]  den_r   [PTG_DIV_STAGES];
  logic [7:0]  quo_r   [PTG_DIV_STAGES];
  logic [7:0]  rem_nxt [PTG_DIV_STAGES];
  logic [15:0] num_nxt [PTG_DIV_STAGES];
  logic [7:0]  den_nxt [PTG_DIV_STAGES];
  logic [7:0]  quo_nxt [PTG_DIV_STAGES];

  // Each stage retires four dividend bits; upper quotient bits shift out unused
  always_comb begin
    logic [7:0]  rem;
    logic [15:0] nm;
    logic [7:0]  dn;
    logic [7:0]  qt;
    logic [8:0]  sh;
    for (int k = 0; k < PTG_DIV_STAGES; k++) begin
      if (k == 0) begin
        rem = '0;
        nm  = num;
        dn  = den;
        qt  = '0;
      end else begin
        rem = rem_r[k-1];
        nm  = num_r[k-1];
        dn  = den_r[k-1];
        qt  = quo_r[k-1];
      end
      for (int j = 0; j < PTG_DIV_STEPS; j++) begin
        sh = {rem, nm[15]};
        nm = {nm[14:0], 1'b0};
        if (sh >= {1'b0, dn}) begin
          rem = 8'(sh - {1'b0, dn});
          qt  = {qt[6:0], 1'b1};
        end else begin
          rem = sh[7:0];
          qt  = {qt[6:0], 1'b0};
        end
      end
      rem_nxt[k] = rem;
      num_nxt[k] = nm;
      den_nxt[k] = dn;
      quo_nxt[k] = qt;
    end
  end

  // Advance all stages every cycle
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quo = quo_r[PTG_DIV_STAGES-1];

endmodule

>>> rtl/ptg_yuv.sv
`timescale 1ns / 1ps
// Four-stage YUV to clamped RGB lane: integer BT.601 or 16-bit fixed-point coefficients.
// Depends on ptg_pkg for coefficients and the wide arithmetic type.
module ptg_yuv (
  input  logic       clk,
  input  logic [7:0] y,
  input  logic [7:0] u,
  input  logic [7:0] v,
  input  logic       fix,
  output logic [7:0] r,
  output logic [7:0] g,
  output logic [7:0] b
);
  import ptg_pkg::*;

  logic signed [8:0] c_s, d_s, e_s;
  ywide_t c_w, d_w, e_w;
  ywide_t ty_nxt, trv_nxt, tgu_nxt, tgv_nxt, tbu_nxt;
  ywide_t ty_r, trv_r, tgu_r, tgv_r, tbu_r;
  logic   fix1_r, fix2_r;
  ywide_t sr_r, sg_r, sb_r;
  logic signed [18:0] hr_r, hg_r, hb_r;
  logic [7:0] r_r, g_r, b_r;

  function automatic logic [7:0] clamp8(input logic signed [18:0] x);
    logic [7:0] res;
    if (x[18]) begin
      res = 8'd0;
    end else if (|x[17:8]) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // Stage 1: center the samples and form the coefficient products
  always_comb begin
    c_s = $signed({1'b0, y}) - 9'sd16;
    d_s = $signed({1'b0, u}) - 9'sd128;
    e_s = $signed({1'b0, v}) - 9'sd128;
    c_w = ywide_t'(c_s);
    d_w = ywide_t'(d_s);
    e_w = ywide_t'(e_s);
    if (fix) begin
      ty_nxt  = ywide_t'({3'b000, y, 16'h0000});
      trv_nxt = e_w * PTG_F_RV;
      tgu_nxt = d_w * PTG_F_GU;
      tgv_nxt = e_w * PTG_F_GV;
      tbu_nxt = d_w * PTG_F_BU;
    end else begin
      ty_nxt  = c_w * PTG_I_Y + PTG_I_RND;
      trv_nxt = e_w * PTG_I_RV;
      tgu_nxt = d_w * PTG_I_GU;
      tgv_nxt = e_w * PTG_I_GV;
      tbu_nxt = d_w * PTG_I_BU;
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: products
    ty_r   <= ty_nxt;
    trv_r  <= trv_nxt;
    tgu_r  <= tgu_nxt;
    tgv_r  <= tgv_nxt;
    tbu_r  <= tbu_nxt;
    fix1_r <= fix;
    // Stage 2: channel sums
    sr_r   <= ty_r + trv_r;
    sg_r   <= ty_r - tgu_r - tgv_r;
    sb_r   <= ty_r + tbu_r;
    fix2_r <= fix1_r;
    // Stage 3: floor shift by the fraction width
    hr_r   <= fix2_r ? 19'(sr_r >>> 16) : 19'(sr_r >>> 8);
    hg_r   <= fix2_r ? 19'(sg_r >>> 16) : 19'(sg_r >>> 8);
    hb_r   <= fix2_r ? 19'(sb_r >>> 16) : 19'(sb_r >>> 8);
    // Stage 4: clamp to 0..255
    r_r    <= clamp8(hr_r);
    g_r    <= clamp8(hg_r);
    b_r    <= clamp8(hb_r);
  end

  assign r = r_r;
  assign g = g_r;
  assign b = b_r;

endmodule
